// File: src/cpf_pkg.sv
package cpf_pkg;

   // Characters that frame and type a packet
   localparam logic [7:0] CHAR_BANG = 8'h21;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_A    = 8'h41;
   localparam logic [7:0] CHAR_B    = 8'h42;
   localparam logic [7:0] CHAR_C    = 8'h43;
   localparam logic [7:0] CHAR_G    = 8'h47;
   localparam logic [7:0] CHAR_L    = 8'h4C;
   localparam logic [7:0] CHAR_M    = 8'h4D;
   localparam logic [7:0] CHAR_Q    = 8'h51;

   // Packet lengths per type
   localparam logic [4:0] LEN_NONE   = 5'd0;
   localparam logic [4:0] LEN_ACCEL  = 5'd15;
   localparam logic [4:0] LEN_QUAT   = 5'd19;
   localparam logic [4:0] LEN_BUTTON = 5'd5;
   localparam logic [4:0] LEN_COLOR  = 5'd6;

   // Highest store position that a result ever reads
   localparam int LAST_KEPT = 9;

   // End causes
   localparam logic [1:0] CAUSE_TYPE = 2'd0;
   localparam logic [1:0] CAUSE_FULL = 2'd1;
   localparam logic [1:0] CAUSE_IDLE = 2'd2;

   // Tilt directions
   localparam logic [1:0] DIR_NONE  = 2'd0;
   localparam logic [1:0] DIR_RIGHT = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_TIMEOUT = 3'd0;
   localparam logic [2:0] REG_LEVEL1  = 3'd1;
   localparam logic [2:0] REG_LEVEL2  = 3'd2;
   localparam logic [2:0] REG_LEVEL3  = 3'd3;
   localparam logic [2:0] REG_LEVEL4  = 3'd4;

   // Register reset values
   localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
   localparam logic [30:0] LEVEL1_RESET  = 31'd1036831948;
   localparam logic [30:0] LEVEL2_RESET  = 31'd1050253721;
   localparam logic [30:0] LEVEL3_RESET  = 31'd1057803468;
   localparam logic [30:0] LEVEL4_RESET  = 31'd1061997772;

   // Magnitude of positive infinity; anything above is NaN
   localparam logic [30:0] MAG_INF = 31'h7F800000;

   // One finished packet, bytes beyond its length already zeroed
   typedef struct packed {
      logic [4:0]  length;
      logic [1:0]  cause;
      logic [7:0]  type_byte;
      logic [7:0]  byte2;
      logic [7:0]  byte3;
      logic [31:0] y_bits;
   } pkt_type;

   // Tilt thresholds
   typedef struct packed {
      logic [30:0] four;
      logic [30:0] three;
      logic [30:0] two;
      logic [30:0] one;
   } levels_type;

   function automatic logic [4:0] type_length(input logic [7:0] t);
      logic [4:0] len;
      unique case (t)
         CHAR_A, CHAR_G, CHAR_M, CHAR_L: len = LEN_ACCEL;
         CHAR_Q:                         len = LEN_QUAT;
         CHAR_B:                         len = LEN_BUTTON;
         CHAR_C:                         len = LEN_COLOR;
         default:                        len = LEN_NONE;
      endcase
      return len;
   endfunction

endpackage

// File: src/controller_packet_framer_top.sv
// Controller packet framer: takes one beat per cycle while req_stall is low (a
// received byte or an idle tick) and cuts the byte stream into controller
// packets, ending one on its type length, on a count of STORE_BYTES bytes,
// or after timeout_limit idle ticks. Each finished packet yields one result beat
// through the framer's packet register, then the decode stage's result register,
// which adds the button and tilt fields. A new beat is accepted every cycle
// while req_stall is low; req_stall rises only while both registers hold results
// that the consumer has not taken.
module controller_packet_framer_top #(
   parameter int STORE_BYTES = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_mode,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_packet_length,
   output logic [1:0]  rsp_end_cause,
   output logic [7:0]  rsp_type_byte,
   output logic [7:0]  rsp_button_number,
   output logic        rsp_button_pressed,
   output logic [1:0]  rsp_tilt_direction,
   output logic [2:0]  rsp_tilt_steps,
   output logic [31:0] rsp_y_bits,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [30:0] csr_wdata
);
   import cpf_pkg::*;

   logic [15:0] timeout_ff;
   levels_type  levels_ff;
   logic        pkt_valid;
   logic        pkt_ready;
   pkt_type     pkt;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff      <= TIMEOUT_RESET;
         levels_ff.one   <= LEVEL1_RESET;
         levels_ff.two   <= LEVEL2_RESET;
         levels_ff.three <= LEVEL3_RESET;
         levels_ff.four  <= LEVEL4_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_TIMEOUT: timeout_ff      <= csr_wdata[15:0];
            REG_LEVEL1:  levels_ff.one   <= csr_wdata;
            REG_LEVEL2:  levels_ff.two   <= csr_wdata;
            REG_LEVEL3:  levels_ff.three <= csr_wdata;
            REG_LEVEL4:  levels_ff.four  <= csr_wdata;
            default: ;
         endcase
      end
   end

   cpf_framer #(
      .STORE_BYTES(STORE_BYTES)
   ) u_framer (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_rx_byte   (req_rx_byte),
      .timeout_limit (timeout_ff),
      .pkt_valid     (pkt_valid),
      .pkt_ready     (pkt_ready),
      .pkt           (pkt)
   );

   cpf_decode u_decode (
      .clock              (clock),
      .reset              (reset),
      .pkt_valid          (pkt_valid),
      .pkt_ready          (pkt_ready),
      .pkt                (pkt),
      .levels             (levels_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_packet_length  (rsp_packet_length),
      .rsp_end_cause      (rsp_end_cause),
      .rsp_type_byte      (rsp_type_byte),
      .rsp_button_number  (rsp_button_number),
      .rsp_button_pressed (rsp_button_pressed),
      .rsp_tilt_direction (rsp_tilt_direction),
      .rsp_tilt_steps     (rsp_tilt_steps),
      .rsp_y_bits         (rsp_y_bits)
   );

   // No steps means no direction
   a_dir_needs_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tilt_steps == 3'd0 |-> rsp_tilt_direction == DIR_NONE)
      else $error("tilt direction without steps");

   // Only A packets carry tilt data
   a_tilt_only_accel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_type_byte != CHAR_A |-> rsp_y_bits == 32'd0 &&
      rsp_tilt_steps == 3'd0)
      else $error("tilt data on a non-A packet");

   // A button packet ended by type is exactly its length
   a_button_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_cause == CAUSE_TYPE && rsp_type_byte == CHAR_B
      |-> rsp_packet_length == LEN_BUTTON)
      else $error("button packet with wrong length");

   // Stall input only while the packet register is blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> pkt_valid && rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

endmodule

// File: src/cpf_framer.sv
module cpf_framer #(
   parameter int STORE_BYTES = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_mode,
   input  logic [7:0]       req_rx_byte,
   input  logic [15:0]      timeout_limit,
   output logic             pkt_valid,
   input  logic             pkt_ready,
   output cpf_pkg::pkt_type pkt
);
   import cpf_pkg::*;

   localparam int IW = $clog2(STORE_BYTES + 1);

   logic [IW-1:0] fill_ff, fill_in;
   logic [15:0]   idle_ff, idle_in;
   logic [7:0]    store_ff [1:LAST_KEPT];
   logic [7:0]    store_nx [1:LAST_KEPT];
   logic          pkt_valid_ff, pkt_valid_in;
   pkt_type       pkt_ff, pkt_in;

   logic          accept;
   logic          is_byte;
   logic [IW-1:0] widx;
   logic [IW-1:0] new_fill;
   logic [IW-1:0] end_len;
   logic [4:0]    tlen;
   logic [15:0]   idle_inc;
   logic          emit;
   logic [1:0]    cause;
   logic [7:0]    kept [1:LAST_KEPT];

   assign req_stall = pkt_valid_ff && !pkt_ready;
   assign accept    = req_valid && !req_stall;
   assign is_byte   = accept && !req_mode;

   // Write position: a bang restarts the packet
   assign widx     = (req_rx_byte == CHAR_BANG) ? '0 : fill_ff;
   assign new_fill = widx + IW'(1);
   assign idle_inc = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;

   // Store contents after this beat's byte
   always_comb begin
      for (int i = 1; i <= LAST_KEPT; i++) begin
         store_nx[i] = (is_byte && widx == IW'(i)) ? req_rx_byte : store_ff[i];
      end
   end

   assign tlen = type_length(store_nx[1]);

   // Decide whether this beat ends a packet
   always_comb begin
      fill_in = fill_ff;
      idle_in = idle_ff;
      emit    = 1'b0;
      cause   = CAUSE_TYPE;
      end_len = fill_ff;
      if (accept) begin
         if (!req_mode) begin
            fill_in = new_fill;
            idle_in = '0;
            end_len = new_fill;
            priority if (new_fill == IW'(STORE_BYTES)) begin
               emit  = 1'b1;
               cause = CAUSE_FULL;
            end else if (tlen != LEN_NONE && new_fill == IW'(tlen)) begin
               emit  = 1'b1;
               cause = CAUSE_TYPE;
            end else begin
               emit  = 1'b0;
            end
         end else if (fill_ff == '0) begin
            idle_in = '0;
         end else begin
            idle_in = idle_inc;
            if (idle_inc >= timeout_limit) begin
               emit  = 1'b1;
               cause = CAUSE_IDLE;
            end
         end
         if (emit) begin
            fill_in = '0;
            idle_in = '0;
         end
      end
   end

   // Zero bytes beyond the packet length
   always_comb begin
      for (int i = 1; i <= LAST_KEPT; i++) begin
         kept[i] = (IW'(i) < end_len) ? store_nx[i] : 8'h00;
      end
   end

   always_comb begin
      pkt_in.length    = end_len[4:0];
      pkt_in.cause     = cause;
      pkt_in.type_byte = kept[1];
      pkt_in.byte2     = kept[2];
      pkt_in.byte3     = kept[3];
      pkt_in.y_bits    = {kept[9], kept[8], kept[7], kept[6]};
   end

   // Hold the packet until the decoder takes it
   assign pkt_valid_in = emit || (pkt_valid_ff && !pkt_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         idle_ff      <= '0;
         pkt_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         idle_ff      <= idle_in;
         pkt_valid_ff <= pkt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 1; i <= LAST_KEPT; i++) begin
         store_ff[i] <= store_nx[i];
      end
      if (emit) begin
         pkt_ff <= pkt_in;
      end
   end

   assign pkt_valid = pkt_valid_ff;
   assign pkt       = pkt_ff;

endmodule

// File: src/cpf_decode.sv
module cpf_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                pkt_valid,
   output logic                pkt_ready,
   input  cpf_pkg::pkt_type    pkt,
   input  cpf_pkg::levels_type levels,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [4:0]          rsp_packet_length,
   output logic [1:0]          rsp_end_cause,
   output logic [7:0]          rsp_type_byte,
   output logic [7:0]          rsp_button_number,
   output logic                rsp_button_pressed,
   output logic [1:0]          rsp_tilt_direction,
   output logic [2:0]          rsp_tilt_steps,
   output logic [31:0]         rsp_y_bits
);
   import cpf_pkg::*;

   logic        valid_ff, valid_in;
   logic [4:0]  length_ff;
   logic [1:0]  cause_ff;
   logic [7:0]  type_ff;
   logic [7:0]  bnum_ff, bnum_in;
   logic        bpress_ff, bpress_in;
   logic [1:0]  dir_ff, dir_in;
   logic [2:0]  steps_ff, steps_in;
   logic [31:0] y_ff, y_in;
   logic        take;
   logic [30:0] mag;
   logic [2:0]  steps;

   assign pkt_ready = !valid_ff || !rsp_stall;
   assign take      = pkt_valid && pkt_ready;

   // Count tilt steps from the magnitude bits
   assign mag = pkt.y_bits[30:0];
   always_comb begin
      steps = 3'd0;
      if (mag <= MAG_INF) begin
         priority if (mag > levels.four)  steps = 3'd4;
         else if (mag > levels.three)     steps = 3'd3;
         else if (mag > levels.two)       steps = 3'd2;
         else if (mag > levels.one)       steps = 3'd1;
         else                             steps = 3'd0;
      end
   end

   // Type-specific fields, zero for other types
   always_comb begin
      bnum_in   = 8'h00;
      bpress_in = 1'b0;
      dir_in    = DIR_NONE;
      steps_in  = 3'd0;
      y_in      = '0;
      if (pkt.type_byte == CHAR_B) begin
         bnum_in   = pkt.byte2 - CHAR_ZERO;
         bpress_in = (pkt.byte3 != CHAR_ZERO);
      end
      if (pkt.type_byte == CHAR_A) begin
         y_in     = pkt.y_bits;
         steps_in = steps;
         if (steps != 3'd0) begin
            dir_in = pkt.y_bits[31] ? DIR_RIGHT : DIR_LEFT;
         end
      end
   end

   assign valid_in = take || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         length_ff <= pkt.length;
         cause_ff  <= pkt.cause;
         type_ff   <= pkt.type_byte;
         bnum_ff   <= bnum_in;
         bpress_ff <= bpress_in;
         dir_ff    <= dir_in;
         steps_ff  <= steps_in;
         y_ff      <= y_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_packet_length  = length_ff;
   assign rsp_end_cause      = cause_ff;
   assign rsp_type_byte      = type_ff;
   assign rsp_button_number  = bnum_ff;
   assign rsp_button_pressed = bpress_ff;
   assign rsp_tilt_direction = dir_ff;
   assign rsp_tilt_steps     = steps_ff;
   assign rsp_y_bits         = y_ff;

endmodule
